[rtl/core/rstws_pkg.sv]
// Shared types, codes and sizes for the record slot table with sort.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rstws_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [SLOT_W-1:0] LAST_PAIR = SLOT_W'(SLOTS - 2);

	// operation codes
	localparam logic [2:0] FUNC_INSERT = 3'd0;
	localparam logic [2:0] FUNC_REMOVE = 3'd1;
	localparam logic [2:0] FUNC_LOOKUP = 3'd2;
	localparam logic [2:0] FUNC_RENAME = 3'd3;
	localparam logic [2:0] FUNC_SORT   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	// datapath actions
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_INSERT  = 3'd1;
	localparam logic [2:0] ACT_HIT     = 3'd2;
	localparam logic [2:0] ACT_MISS    = 3'd3;
	localparam logic [2:0] ACT_PLAIN   = 3'd4;
	localparam logic [2:0] ACT_SWAP_LO = 3'd5;
	localparam logic [2:0] ACT_SWAP_HI = 3'd6;

	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] name_key;
		logic [15:0] record_id;
		logic        descending;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_index;
		logic [15:0] assigned_id;
		logic [63:0] found_name;
	} rsp_t;

	typedef struct packed {
		logic [15:0] id;
		logic [63:0] name;
	} entry_t;

	typedef struct packed {
		logic              latch;
		logic              rd_en;
		logic [SLOT_W-1:0] slot;
		logic [2:0]        act;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       used_k;
		logic       used_k1;
		logic       id_match;
		logic       out_of_order;
		logic       out_free;
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/rstws_dp.sv]
// Datapath: slot memory, used bits, id counter, compare logic and result register.
// Depends on rstws_pkg; driven by commands from rstws_ctrl.
`default_nettype none

module rstws_dp
	import rstws_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire req_t  req,
	input  wire cmd_t  cmd,
	output stat_t      stat,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output rsp_t       rsp
);

	req_t              req_q;
	logic [SLOTS-1:0]  used_q;
	logic [15:0]       next_id_q;
	entry_t            mem [SLOTS];
	entry_t            rd_a_q;
	entry_t            rd_b_q;
	rsp_t              res_q;
	rsp_t              res_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [SLOT_W-1:0] slot_nxt;
	logic              free_hit;
	logic [SLOT_W-1:0] free_idx;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;

	assign slot_nxt = cmd.slot + SLOT_W'(1);

	// lowest free slot
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmd.slot;
		wr_data = rd_b_q;
		unique case (cmd.act)
			ACT_INSERT: begin
				wr_en        = free_hit;
				wr_addr      = free_idx;
				wr_data.id   = next_id_q;
				wr_data.name = req_q.name_key;
			end
			ACT_HIT: begin
				wr_en        = (req_q.func == FUNC_RENAME);
				wr_data.id   = rd_a_q.id;
				wr_data.name = req_q.name_key;
			end
			ACT_SWAP_LO: begin
				wr_en = 1'b1;
			end
			ACT_SWAP_HI: begin
				wr_en   = 1'b1;
				wr_addr = slot_nxt;
				wr_data = rd_a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_a_q <= mem[cmd.slot];
			rd_b_q <= mem[slot_nxt];
		end
	end

	always_comb begin
		res_d = '0;
		unique case (cmd.act)
			ACT_INSERT: begin
				if (free_hit) begin
					res_d.status      = ST_OK;
					res_d.slot_index  = 4'(free_idx);
					res_d.assigned_id = next_id_q;
				end else begin
					res_d.status = ST_FULL;
				end
			end
			ACT_HIT: begin
				res_d.status      = ST_OK;
				res_d.slot_index  = 4'(cmd.slot);
				res_d.assigned_id = rd_a_q.id;
				if (req_q.func == FUNC_LOOKUP) begin
					res_d.found_name = rd_a_q.name;
				end
			end
			ACT_MISS: begin
				res_d.status = ST_NOTFOUND;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.act == ACT_INSERT || cmd.act == ACT_HIT || cmd.act == ACT_MISS ||
		    cmd.act == ACT_PLAIN) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			next_id_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.act == ACT_INSERT && free_hit) begin
				used_q[free_idx] <= 1'b1;
				next_id_q        <= next_id_q + 16'd1;
			end
			if (cmd.act == ACT_HIT && req_q.func == FUNC_REMOVE) begin
				used_q[cmd.slot] <= 1'b0;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.func         = req_q.func;
		stat.used_k       = used_q[cmd.slot];
		stat.used_k1      = used_q[slot_nxt];
		stat.id_match     = (rd_a_q.id == req_q.record_id);
		stat.out_of_order = req_q.descending ? (rd_a_q.name < rd_b_q.name)
		                                     : (rd_a_q.name > rd_b_q.name);
		stat.out_free     = !rsp_valid_q || !rsp_stall;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[rtl/core/rstws_ctrl.sv]
// Controller: sequences insert, id scans and bubble-sort passes over the slots.
// Depends on rstws_pkg; commands rstws_dp and reads its status.
`default_nettype none

module rstws_ctrl
	import rstws_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISP     = 3'd1;
	localparam logic [2:0] S_SCAN_RD  = 3'd2;
	localparam logic [2:0] S_SCAN_CHK = 3'd3;
	localparam logic [2:0] S_SORT_RD  = 3'd4;
	localparam logic [2:0] S_SORT_CMP = 3'd5;
	localparam logic [2:0] S_SORT_SWP = 3'd6;
	localparam logic [2:0] S_FIN      = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic [SLOT_W-1:0] k_q;
	logic [SLOT_W-1:0] k_d;
	logic              swapped_q;
	logic              swapped_d;
	logic              adv;

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		swapped_d    = swapped_q;
		adv          = 1'b0;
		cmd.latch    = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.slot     = k_q;
		cmd.act      = ACT_NONE;
		cmd.out_load = 1'b0;
		req_stall    = (state_q != S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.func)
					FUNC_INSERT: begin
						cmd.act = ACT_INSERT;
						state_d = S_FIN;
					end
					FUNC_REMOVE, FUNC_LOOKUP, FUNC_RENAME: begin
						k_d     = '0;
						state_d = S_SCAN_RD;
					end
					FUNC_SORT: begin
						k_d       = '0;
						swapped_d = 1'b0;
						state_d   = S_SORT_RD;
					end
					default: begin
						cmd.act = ACT_PLAIN;
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN_RD: begin
				if (stat.used_k) begin
					cmd.rd_en = 1'b1;
					state_d   = S_SCAN_CHK;
				end else if (k_q == LAST_SLOT) begin
					cmd.act = ACT_MISS;
					state_d = S_FIN;
				end else begin
					k_d = k_q + SLOT_W'(1);
				end
			end
			S_SCAN_CHK: begin
				if (stat.id_match) begin
					cmd.act = ACT_HIT;
					state_d = S_FIN;
				end else if (k_q == LAST_SLOT) begin
					cmd.act = ACT_MISS;
					state_d = S_FIN;
				end else begin
					k_d     = k_q + SLOT_W'(1);
					state_d = S_SCAN_RD;
				end
			end
			S_SORT_RD: begin
				if (stat.used_k && stat.used_k1) begin
					cmd.rd_en = 1'b1;
					state_d   = S_SORT_CMP;
				end else begin
					adv = 1'b1;
				end
			end
			S_SORT_CMP: begin
				if (stat.out_of_order) begin
					cmd.act   = ACT_SWAP_LO;
					swapped_d = 1'b1;
					state_d   = S_SORT_SWP;
				end else begin
					adv = 1'b1;
				end
			end
			S_SORT_SWP: begin
				cmd.act = ACT_SWAP_HI;
				adv     = 1'b1;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// step to the next pair, or close the pass
		if (adv) begin
			if (k_q == LAST_PAIR) begin
				if (swapped_q) begin
					k_d       = '0;
					swapped_d = 1'b0;
					state_d   = S_SORT_RD;
				end else begin
					cmd.act = ACT_PLAIN;
					state_d = S_FIN;
				end
			end else begin
				k_d     = k_q + SLOT_W'(1);
				state_d = S_SORT_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			k_q       <= '0;
			swapped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			k_q       <= k_d;
			swapped_q <= swapped_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/record_slot_table_with_sort_top.sv]
// Top level of the record slot table with sort: controller plus datapath.
// Depends on rstws_pkg, rstws_ctrl and rstws_dp.
//
// Channels: req (req_valid / req_stall / req) takes one operation item
//   (insert, remove, lookup, rename, sort); rsp (rsp_valid / rsp_stall /
//   rsp) returns exactly one result item per request, in order. An item
//   moves when valid is high and stall is low at a rising edge.
// Operation: one item is worked on at a time, and req_stall
//   stays high from the accept until its result is loaded into the output
//   register. Insert and unknown operations go straight to that load.
//   Remove, lookup and rename scan the slots in order, reading each used
//   slot and comparing its id, up to the match. Sort runs bubble passes
//   over adjacent slot pairs, skipping a pair that holds a free slot,
//   comparing used pairs and swapping out-of-order ones, and repeats
//   passes until one pass swaps nothing (up to SLOTS passes).
// Reset and stall: arst_n clears the used marks, the id counter, the result
//   valid and the control state; slot contents are not cleared. A stalled
//   result holds in the output register; the next request is still taken,
//   and its result waits until the output register frees.
`default_nettype none

module record_slot_table_with_sort_top
	import rstws_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	cmd_t  cmd;
	stat_t stat;

	// sequence each operation over the slots
	rstws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold the table, compare names and ids, drive the result register
	rstws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[rtl/core/rstws_chk.sv]
// Port-level checker for the record slot table with sort, bound to the top.
// Depends on rstws_pkg and record_slot_table_with_sort_top.
`default_nettype none

module rstws_chk
	import rstws_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	// a stalled result item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result item changed while stalled");

	// one item at a time: the block is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while previous item still in work");

	// a failed operation carries no slot, id or name
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |->
			rsp.slot_index == 4'd0 && rsp.assigned_id == 16'd0 &&
			rsp.found_name == 64'd0)
		else $error("failed result carries data");

	// a new result only appears while an item was in work
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result item without a request in work");

endmodule

bind record_slot_table_with_sort_top rstws_chk u_rstws_chk (.*);

`default_nettype wire
